>>> design/alfr_pkg.sv
// shared types and constants for the audio link frame receiver
`default_nettype none
package alfr_pkg;

    localparam int WIN_BYTES = 16;
    localparam logic [7:0] SYNC_A = 8'ha5;
    localparam logic [7:0] SYNC_B = 8'h5a;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
    localparam logic [15:0] EXPECTED_RESET = 16'h0601;
    localparam logic [15:0] TIMER_MAX      = 16'hffff;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic CFG_PAYLOAD_TIMEOUT = 1'b0;
    localparam logic CFG_EXPECTED_CMD    = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] frame_command;
        logic [15:0] frame_length;
        logic        payload_cut_short;
        logic        command_matches;
    } t_result;

endpackage
`default_nettype wire

>>> design/alfr_in_stage.sv
// input register with valid/stall handshake
`default_nettype none
module alfr_in_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire alfr_pkg::t_in_item  i_item,
    input  wire logic                i_advance,
    output logic                     o_valid,
    output alfr_pkg::t_in_item       o_item
);
    import alfr_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_take;

    // the register frees up whenever its item moves on in the same cycle
    assign o_stall = r_valid && !i_advance;
    assign w_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

>>> design/alfr_frame_core.sv
// header search window, payload skip state and configuration registers
`default_nettype none
module alfr_frame_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic                i_step,
    input  wire alfr_pkg::t_in_item  i_item,
    output logic                     o_res_valid,
    output alfr_pkg::t_result        o_res
);
    import alfr_pkg::*;

    logic [15:0] r_timeout;
    logic [15:0] r_expected;

    logic [7:0]  r_window [WIN_BYTES];
    logic        r_skipping;
    logic [15:0] r_payload_left;
    logic [15:0] r_skip_timer;
    logic [15:0] r_held_command;
    logic [15:0] r_held_length;

    logic [7:0]  n_window [WIN_BYTES];
    logic        n_skipping;
    logic [15:0] n_payload_left;
    logic [15:0] n_skip_timer;
    logic [15:0] n_held_command;
    logic [15:0] n_held_length;

    logic        w_emit;
    logic        w_cut;
    logic        w_clear;
    logic [15:0] w_timer_inc;
    logic [15:0] w_left_dec;
    logic [15:0] w_cmd;
    logic [15:0] w_len;
    logic        w_sync;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_expected <= EXPECTED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAYLOAD_TIMEOUT: r_timeout  <= i_cfg_data;
                CFG_EXPECTED_CMD:    r_expected <= i_cfg_data;
                default:             r_timeout  <= r_timeout;
            endcase
        end
    end

    assign w_timer_inc = (r_skip_timer != TIMER_MAX) ? r_skip_timer + 16'd1 : r_skip_timer;
    assign w_left_dec  = (r_payload_left != 16'd0) ? r_payload_left - 16'd1 : r_payload_left;

    // after the shift, window bytes 0..3 are today's bytes 1..4
    assign w_sync = (r_window[1] == SYNC_A) && (r_window[2] == SYNC_A) &&
                    (r_window[3] == SYNC_B) && (r_window[4] == SYNC_B);
    assign w_cmd  = {r_window[8], r_window[7]};
    assign w_len  = {r_window[10], r_window[9]};

    always_comb begin
        n_skipping     = r_skipping;
        n_payload_left = r_payload_left;
        n_skip_timer   = r_skip_timer;
        n_held_command = r_held_command;
        n_held_length  = r_held_length;
        for (int k = 0; k < WIN_BYTES; k++) begin
            n_window[k] = r_window[k];
        end
        w_emit  = 1'b0;
        w_cut   = 1'b0;
        w_clear = 1'b0;

        if (r_skipping) begin
            if (i_item.req_type == REQ_TICK) begin
                n_skip_timer = w_timer_inc;
                if (w_timer_inc >= r_timeout) begin
                    w_emit = 1'b1;
                    w_cut  = 1'b1;
                end
            end else begin
                n_payload_left = w_left_dec;
                if (w_left_dec == 16'd0) begin
                    w_emit = 1'b1;
                end
            end
        end else if (i_item.req_type == REQ_BYTE) begin
            for (int k = 0; k < WIN_BYTES - 1; k++) begin
                n_window[k] = r_window[k + 1];
            end
            n_window[WIN_BYTES - 1] = i_item.rx_byte;
            if (w_sync) begin
                n_held_command = w_cmd;
                n_held_length  = w_len;
                if (w_len == 16'd0) begin
                    w_emit = 1'b1;
                end else if (r_timeout == 16'd0) begin
                    w_emit = 1'b1;
                    w_cut  = 1'b1;
                end else begin
                    n_skipping     = 1'b1;
                    n_payload_left = w_len;
                    n_skip_timer   = 16'd0;
                end
            end
        end

        // a reported frame leaves a clean window behind
        if (w_emit) begin
            w_clear        = 1'b1;
            n_skipping     = 1'b0;
            n_payload_left = 16'd0;
            n_skip_timer   = 16'd0;
            for (int k = 0; k < WIN_BYTES; k++) begin
                n_window[k] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skipping     <= 1'b0;
            r_payload_left <= 16'd0;
            r_skip_timer   <= 16'd0;
            r_held_command <= 16'd0;
            r_held_length  <= 16'd0;
            for (int k = 0; k < WIN_BYTES; k++) begin
                r_window[k] <= 8'h00;
            end
        end else if (i_step) begin
            r_skipping     <= n_skipping;
            r_payload_left <= n_payload_left;
            r_skip_timer   <= n_skip_timer;
            r_held_command <= n_held_command;
            r_held_length  <= n_held_length;
            for (int k = 0; k < WIN_BYTES; k++) begin
                r_window[k] <= n_window[k];
            end
        end
    end

    assign o_res_valid             = i_step && w_emit && w_clear;
    assign o_res.frame_command     = n_held_command;
    assign o_res.frame_length      = n_held_length;
    assign o_res.payload_cut_short = w_cut;
    assign o_res.command_matches   = (n_held_command == r_expected);

endmodule
`default_nettype wire

>>> design/alfr_out_stage.sv
// result register towards the output channel
`default_nettype none
module alfr_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_res_valid,
    input  wire alfr_pkg::t_result  i_res,
    input  wire logic               i_stall,
    output logic                    o_advance,
    output logic                    o_valid,
    output alfr_pkg::t_result       o_res
);
    import alfr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

>>> design/audio_link_frame_receiver_core.sv
// an accepted item is held in the input register; its result is registered in the output stage
// throughput: one item per cycle while the output is not stalled, set by the single pass through the frame core
// a stalled result holds the pipeline; the input register still takes one item meanwhile
// reset (synchronous, active low): window and skip state cleared, registers to defaults
`default_nettype none
module audio_link_frame_receiver_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_frame_command,
    output logic [15:0]      o_frame_length,
    output logic             o_payload_cut_short,
    output logic             o_command_matches,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import alfr_pkg::*;

    t_in_item w_in_item;
    t_in_item w_s1_item;
    logic     w_s1_valid;
    logic     w_advance;
    logic     w_res_valid;
    t_result  w_res;
    t_result  w_out_res;

    assign w_in_item.req_type = i_req_type;
    assign w_in_item.rx_byte  = i_rx_byte;

    alfr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_s1_valid),
        .o_item    (w_s1_item)
    );

    alfr_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (w_s1_valid && w_advance),
        .i_item      (w_s1_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    alfr_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_stall     (i_out_stall),
        .o_advance   (w_advance),
        .o_valid     (o_out_valid),
        .o_res       (w_out_res)
    );

    assign o_frame_command     = w_out_res.frame_command;
    assign o_frame_length      = w_out_res.frame_length;
    assign o_payload_cut_short = w_out_res.payload_cut_short;
    assign o_command_matches   = w_out_res.command_matches;

endmodule
`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the audio link frame receiver core
module testbench;
    import alfr_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 220;

    // predicts the frames of the receiver and holds those still to come
    class frame_scoreboard;
        logic [7:0]  window [WIN_BYTES];
        bit          skipping;
        logic [15:0] bytes_left;
        logic [15:0] ticks_seen;
        logic [15:0] held_cmd;
        logic [15:0] held_len;
        logic [15:0] timeout_ticks;
        logic [15:0] expected_cmd;
        t_result     frames_due [$];
        int          errors;

        function new();
            foreach (window[i]) window[i] = 8'h00;
            skipping      = 1'b0;
            bytes_left    = '0;
            ticks_seen    = '0;
            held_cmd      = '0;
            held_len      = '0;
            timeout_ticks = TIMEOUT_RESET;
            expected_cmd  = EXPECTED_RESET;
            errors        = 0;
        endfunction

        function void close_frame(bit cut);
            t_result r;
            r.frame_command     = held_cmd;
            r.frame_length      = held_len;
            r.payload_cut_short = cut;
            r.command_matches   = (held_cmd == expected_cmd);
            frames_due.push_back(r);
            foreach (window[i]) window[i] = 8'h00;
            skipping   = 1'b0;
            bytes_left = '0;
            ticks_seen = '0;
        endfunction

        function void note_item(logic req_type, logic [7:0] rx_byte);
            if (skipping) begin
                if (req_type == REQ_TICK) begin
                    if (ticks_seen < TIMER_MAX) ticks_seen++;
                    if (ticks_seen >= timeout_ticks) close_frame(1'b1);
                end else begin
                    if (bytes_left != 0) bytes_left--;
                    if (bytes_left == 0) close_frame(1'b0);
                end
            end else if (req_type == REQ_BYTE) begin
                for (int i = 0; i < WIN_BYTES - 1; i++) window[i] = window[i + 1];
                window[WIN_BYTES - 1] = rx_byte;
                if (window[0] == SYNC_A && window[1] == SYNC_A &&
                        window[2] == SYNC_B && window[3] == SYNC_B) begin
                    held_cmd = {window[7], window[6]};
                    held_len = {window[9], window[8]};
                    if (held_len == 0) begin
                        close_frame(1'b0);
                    end else if (timeout_ticks == 0) begin
                        close_frame(1'b1);
                    end else begin
                        skipping   = 1'b1;
                        bytes_left = held_len;
                        ticks_seen = '0;
                    end
                end
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_frame(t_result got);
            t_result want;
            if (frames_due.size() == 0) begin
                report($sformatf("frame with none due: cmd %h len %h",
                                 got.frame_command, got.frame_length));
                return;
            end
            want = frames_due.pop_front();
            if (got.frame_command != want.frame_command)
                report($sformatf("frame_command %h, want %h",
                                 got.frame_command, want.frame_command));
            if (got.frame_length != want.frame_length)
                report($sformatf("frame_length %h, want %h",
                                 got.frame_length, want.frame_length));
            if (got.payload_cut_short != want.payload_cut_short)
                report($sformatf("payload_cut_short %b, want %b (cmd %h)",
                                 got.payload_cut_short, want.payload_cut_short,
                                 want.frame_command));
            if (got.command_matches != want.command_matches)
                report($sformatf("command_matches %b, want %b (cmd %h)",
                                 got.command_matches, want.command_matches,
                                 want.frame_command));
        endtask

        task flush_leftovers();
            if (frames_due.size() != 0)
                report($sformatf("%0d frames never arrived", frames_due.size()));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n             = 1'b0;
    logic        i_in_valid          = 1'b0;
    logic        i_req_type          = REQ_BYTE;
    logic [7:0]  i_rx_byte           = 8'h00;
    logic        i_out_stall         = 1'b0;
    logic        i_cfg_we            = 1'b0;
    logic        i_cfg_index         = CFG_PAYLOAD_TIMEOUT;
    logic [15:0] i_cfg_data          = 16'h0000;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_frame_command;
    logic [15:0] o_frame_length;
    logic        o_payload_cut_short;
    logic        o_command_matches;

    frame_scoreboard sb = new();
    t_in_item        stim_q [$];
    bit              idle_on      = 1'b1;
    bit              hold_req     = 1'b0;
    bit              hold_done    = 1'b0;
    int              hold_left    = 0;
    int              burst_left   = 0;
    logic [15:0]     cur_timeout  = TIMEOUT_RESET;
    logic [15:0]     cur_expected = EXPECTED_RESET;

    audio_link_frame_receiver_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_req_type          (i_req_type),
        .i_rx_byte           (i_rx_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_frame_command     (o_frame_command),
        .o_frame_length      (o_frame_length),
        .o_payload_cut_short (o_payload_cut_short),
        .o_command_matches   (o_command_matches),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("testbench failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_item(i_req_type, i_rx_byte);
            if (o_out_valid && !i_out_stall)
                sb.check_frame({o_frame_command, o_frame_length,
                                o_payload_cut_short, o_command_matches});
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left  <= burst_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst_left  <= $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic void add_byte(logic [7:0] b);
        stim_q.push_back('{REQ_BYTE, b});
    endfunction

    // rx_byte rides along with a tick and must be ignored
    function automatic void add_tick();
        stim_q.push_back('{REQ_TICK, rand_byte()});
    endfunction

    function automatic void add_header(logic [15:0] cmd, logic [15:0] len);
        add_byte(SYNC_A);
        add_byte(SYNC_A);
        add_byte(SYNC_B);
        add_byte(SYNC_B);
        add_byte(rand_byte());
        add_byte(rand_byte());
        add_byte(cmd[7:0]);
        add_byte(cmd[15:8]);
        add_byte(len[7:0]);
        add_byte(len[15:8]);
        repeat (6) add_byte(rand_byte());
    endfunction

    function automatic void add_random_frame();
        logic [15:0] cmd;
        logic [15:0] len;
        int          left;
        int          ticks;
        int          budget;
        int          tick_odds;
        case ($urandom_range(0, 5))
            0, 1:    cmd = cur_expected;
            2:       cmd = 16'h0000;
            3:       cmd = 16'hffff;
            default: cmd = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       len = 16'h0000;
            1:       len = (cur_timeout <= 40) ? ($urandom_range(0, 1) ? 16'hffff :
                           16'($urandom_range(256, 65535))) : 16'($urandom_range(1, 12));
            default: len = 16'($urandom_range(1, 12));
        endcase
        add_header(cmd, len);
        left      = len;
        ticks     = 0;
        budget    = 0;
        tick_odds = (len > 200) ? 1 : 4;
        while (left > 0 && ticks < cur_timeout && budget < 150) begin
            if ($urandom_range(0, tick_odds) == 0) begin
                add_tick();
                ticks++;
            end else begin
                add_byte(rand_byte());
                left--;
            end
            budget++;
        end
        // long payloads end by timeout
        while (left > 0 && ticks < cur_timeout && cur_timeout <= 200) begin
            add_tick();
            ticks++;
        end
    endfunction

    // bytes leaning towards the sync values, with ticks mixed in
    function automatic void add_noise();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
                0:       add_byte(SYNC_A);
                1:       add_byte(SYNC_B);
                2:       add_tick();
                default: add_byte(rand_byte());
            endcase
        end
    endfunction

    // start of a sync pattern that never completes
    function automatic void add_broken_sync();
        int k;
        k = $urandom_range(1, 3);
        add_byte(SYNC_A);
        if (k > 1) add_byte(SYNC_A);
        if (k > 2) add_byte(SYNC_B);
        add_byte(8'h00);
        repeat ($urandom_range(0, 10)) add_byte(rand_byte());
    endfunction

    task automatic drive_all();
        t_in_item it;
        while (stim_q.size() > 0) begin
            it = stim_q.pop_front();
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_req_type <= it.req_type;
            i_rx_byte  <= it.rx_byte;
            do @(posedge i_clk); while (o_in_stall);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while ((sb.frames_due.size() != 0 || hold_left != 0) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        // items with no frame may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [15:0] timeout, logic [15:0] expected);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PAYLOAD_TIMEOUT;
        i_cfg_data  <= timeout;
        @(posedge i_clk);
        i_cfg_index <= CFG_EXPECTED_CMD;
        i_cfg_data  <= expected;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        sb.timeout_ticks = timeout;
        sb.expected_cmd  = expected;
        cur_timeout      = timeout;
        cur_expected     = expected;
    endtask

    task automatic run_random(int target);
        while (stim_q.size() < target) begin
            case ($urandom_range(0, 9))
                0:       add_noise();
                1:       add_broken_sync();
                2:       add_tick();
                default: add_random_frame();
            endcase
        end
        drive_all();
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults: tick outside a frame, zero length, short payload
        stim_q.push_back('{REQ_TICK, 8'hff});
        add_header(EXPECTED_RESET, 16'h0000);
        add_header(16'hffff, 16'h0002);
        add_byte(8'h00);
        add_tick();
        add_byte(8'hff);
        drive_all();
        drain();

        // zero timeout cuts every nonempty payload at once
        write_regs(16'h0000, 16'h0000);
        add_header(16'h0000, 16'h0005);
        add_header(16'h8001, 16'hffff);
        drive_all();
        drain();

        write_regs(16'h0002, 16'hffff);
        add_header(16'hffff, 16'hffff);
        repeat (3) add_tick();
        add_header(16'h8000, 16'h0001);
        add_byte(8'h7f);
        drive_all();
        drain();

        write_regs(16'h0001, 16'hffff);
        run_random(PHASE_ITEMS);

        write_regs(16'hffff, 16'($urandom));
        run_random(PHASE_ITEMS);

        write_regs(TIMEOUT_RESET, EXPECTED_RESET);
        idle_on = 1'b0;
        run_random(PHASE_ITEMS);
        idle_on = 1'b1;

        // long hold-off on the result side while zero-length frames keep coming
        write_regs(16'h0005, 16'($urandom));
        hold_req = 1'b1;
        while (hold_left == 0) @(posedge i_clk);
        repeat (10) add_header(($urandom_range(0, 1) ? cur_expected : 16'($urandom)),
                               16'h0000);
        drive_all();
        drain();

        write_regs(16'($urandom_range(2, 12)), 16'($urandom));
        run_random(PHASE_ITEMS);

        write_regs(16'($urandom_range(13, 40)), 16'h0000);
        run_random(PHASE_ITEMS);

        idle_on = 1'b0;
        write_regs(16'($urandom_range(3, 30)), EXPECTED_RESET);
        run_random(PHASE_ITEMS);

        sb.flush_leftovers();
        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/alfr_pkg.sv
design/alfr_in_stage.sv
design/alfr_frame_core.sv
design/alfr_out_stage.sv
design/audio_link_frame_receiver_core.sv
tb/testbench.sv
